FILE: hdl/sftp_pkg.sv
// shared types and constants for the speed from timestamped position core
// used by sftp_ctrl, sftp_datapath and speed_from_timestamped_position_core
`default_nettype none

package sftp_pkg;

    localparam int TS_FIELD_WIDTH  = 32;
    localparam int TIME_WIDTH      = 32;
    localparam int POS_WIDTH       = 32;
    localparam int DIFF_WIDTH      = POS_WIDTH + 1;
    localparam int NUM_WIDTH       = DIFF_WIDTH + 1;
    localparam int MAG_WIDTH       = NUM_WIDTH - 1;
    localparam int SPEED_WIDTH     = 34;
    localparam int STEP_CNT_WIDTH  = $clog2(MAG_WIDTH);
    localparam int IDLE_WIDTH      = 9;
    localparam int IN_DATA_WIDTH   = ((TS_FIELD_WIDTH + POS_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_WIDTH  = ((SPEED_WIDTH + 7) / 8) * 8;
    localparam int APB_ADDR_WIDTH  = 3;
    localparam int APB_DATA_WIDTH  = 32;

    localparam logic [IDLE_WIDTH-1:0]     IDLE_MAX      = '1;
    localparam logic [IDLE_WIDTH-1:0]     TIMEOUT_RESET = IDLE_WIDTH'(300);
    localparam logic [STEP_CNT_WIDTH-1:0] LAST_STEP     = STEP_CNT_WIDTH'(MAG_WIDTH - 1);

    // register word indexes
    localparam logic REG_TIMEOUT_TICKS = 1'b0;

    typedef struct packed {
        logic load;
        logic prep;
        logic step;
        logic commit_div;
        logic commit_idle;
        logic out_load;
    } sftp_cmd_t;

    typedef struct packed {
        logic new_sample;
        logic div_last;
    } sftp_stat_t;

endpackage

`default_nettype wire

FILE: hdl/speed_from_timestamped_position_core.sv
// top level: stream ports, apb timeout register, controller and datapath
// depends on sftp_pkg, sftp_ctrl and sftp_datapath
//
// channel   direction  handshake            payload
// s_*       in         s_tvalid / s_tready  timestamp, position
// m_*       out        m_tvalid / m_tready  speed
// apb       in         psel / penable       timeout_ticks register at byte 0
//
// a new timestamp goes from request to result through load, operand prep,
// 33 restoring divide steps (one quotient bit each), commit and output load
// a repeated timestamp goes from load straight to output load, no divide
// one request in flight; the next is taken while the result waits in m_tdata
// asynchronous active-low reset clears the stored sample, idle count and held speed
`default_nettype none

module speed_from_timestamped_position_core
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [31:0] timestamp, [63:32] position
    input  wire logic [sftp_pkg::IN_DATA_WIDTH-1:0]  s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [33:0] speed, upper bits zero
    output logic [sftp_pkg::OUT_DATA_WIDTH-1:0]      m_tdata,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [sftp_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  wire logic [sftp_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic [sftp_pkg::APB_DATA_WIDTH-1:0]      prdata,
    output logic                                     pready
);
    import sftp_pkg::*;

    sftp_cmd_t                     cmd;
    sftp_stat_t                    stat;
    logic [IDLE_WIDTH-1:0]         timeout_reg;
    logic                          reg_sel;
    logic signed [SPEED_WIDTH-1:0] speed;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[APB_ADDR_WIDTH-1] == REG_TIMEOUT_TICKS);
    assign prdata  = reg_sel ? APB_DATA_WIDTH'(timeout_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            timeout_reg <= pwdata[IDLE_WIDTH-1:0];
        end
    end

    assign m_tdata = OUT_DATA_WIDTH'($unsigned(speed));

    sftp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sftp_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .timestamp     (s_tdata[TS_FIELD_WIDTH-1:0]),
        .position      (s_tdata[TS_FIELD_WIDTH +: POS_WIDTH]),
        .timeout_ticks (timeout_reg),
        .speed         (speed)
    );

endmodule

`default_nettype wire

FILE: hdl/sftp_ctrl.sv
// controller state machine: request acceptance, divide sequencing, result hand-off
// depends on sftp_pkg; drives the command struct of sftp_datapath
`default_nettype none

module sftp_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    input  wire sftp_pkg::sftp_stat_t stat,
    output sftp_pkg::sftp_cmd_t     cmd
);
    import sftp_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIVIDE,
        ST_COMMIT,
        ST_OUTPUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.load        = accept;
        cmd.prep        = (state_reg == ST_PREP);
        cmd.step        = (state_reg == ST_DIVIDE);
        cmd.commit_div  = (state_reg == ST_COMMIT);
        cmd.commit_idle = accept && !stat.new_sample;
        cmd.out_load    = (state_reg == ST_OUTPUT) && out_free;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = stat.new_sample ? ST_PREP : ST_OUTPUT;
                end
            end
            ST_PREP:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (stat.div_last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_OUTPUT;
            end
            ST_OUTPUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/sftp_datapath.sv
// datapath: stored sample, idle counter, held speed, bit-serial restoring divider
// depends on sftp_pkg; steered by sftp_ctrl through the command struct
`default_nettype none

module sftp_datapath
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire sftp_pkg::sftp_cmd_t                   cmd,
    output sftp_pkg::sftp_stat_t                       stat,
    input  wire logic [sftp_pkg::TS_FIELD_WIDTH-1:0]   timestamp,
    input  wire logic signed [sftp_pkg::POS_WIDTH-1:0] position,
    input  wire logic [sftp_pkg::IDLE_WIDTH-1:0]       timeout_ticks,
    output logic signed [sftp_pkg::SPEED_WIDTH-1:0]    speed
);
    import sftp_pkg::*;

    logic [TIME_WIDTH-1:0]         prev_time_reg;
    logic signed [POS_WIDTH-1:0]   prev_pos_reg;
    logic [IDLE_WIDTH-1:0]         idle_reg;
    logic signed [SPEED_WIDTH-1:0] held_reg;
    logic signed [SPEED_WIDTH-1:0] out_reg;

    logic [TIME_WIDTH-1:0]         ts_reg;
    logic signed [POS_WIDTH-1:0]   pos_reg;
    logic [TIME_WIDTH-1:0]         den_reg;
    logic signed [NUM_WIDTH-1:0]   num_reg;
    logic                          neg_reg;
    logic [MAG_WIDTH-1:0]          mag_reg;
    logic [TIME_WIDTH-1:0]         rem_reg;
    logic [STEP_CNT_WIDTH-1:0]     cnt_reg;

    logic [TIME_WIDTH-1:0]         ts_in;
    logic signed [DIFF_WIDTH-1:0]  diff;
    logic [TIME_WIDTH:0]           trial;
    logic [TIME_WIDTH+1:0]         trial_sub;
    logic                          ge;
    logic [IDLE_WIDTH-1:0]         idle_next;
    logic [SPEED_WIDTH-1:0]        quot_ext;

    assign ts_in = timestamp[TIME_WIDTH-1:0];
    assign diff  = DIFF_WIDTH'(position) - DIFF_WIDTH'(prev_pos_reg);

    // one quotient bit per step
    assign trial     = {rem_reg, mag_reg[MAG_WIDTH-1]};
    assign trial_sub = {1'b0, trial} - {2'b00, den_reg};
    assign ge        = !trial_sub[TIME_WIDTH+1];

    assign idle_next = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 1'b1;
    assign quot_ext  = SPEED_WIDTH'(mag_reg);

    assign stat.new_sample = (ts_in != prev_time_reg);
    assign stat.div_last   = (cnt_reg == LAST_STEP);
    assign speed           = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_time_reg <= '0;
            prev_pos_reg  <= '0;
            idle_reg      <= '0;
            held_reg      <= '0;
        end
        else
        begin
            if (cmd.commit_div)
            begin
                prev_time_reg <= ts_reg;
                prev_pos_reg  <= pos_reg;
                idle_reg      <= '0;
                held_reg      <= neg_reg ? -$signed(quot_ext) : $signed(quot_ext);
            end
            else if (cmd.commit_idle)
            begin
                idle_reg <= idle_next;
                if (idle_next > timeout_ticks)
                begin
                    held_reg <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ts_reg  <= ts_in;
            pos_reg <= position;
            den_reg <= ts_in - prev_time_reg;
            num_reg <= {diff, 1'b0};
        end
        if (cmd.prep)
        begin
            neg_reg <= num_reg[NUM_WIDTH-1];
            mag_reg <= num_reg[NUM_WIDTH-1] ? MAG_WIDTH'(-num_reg) : MAG_WIDTH'(num_reg);
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.step)
        begin
            rem_reg <= ge ? trial_sub[TIME_WIDTH-1:0] : trial[TIME_WIDTH-1:0];
            mag_reg <= {mag_reg[MAG_WIDTH-2:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.out_load)
        begin
            out_reg <= held_reg;
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/speed_estimate_checker.sv
// checker for speed_from_timestamped_position_core: watches the request, result and apb
// channels, predicts every speed and compares it; depends on sftp_pkg

module speed_estimate_checker
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    input  wire logic                                s_tready,
    // [31:0] timestamp, [63:32] position
    input  wire logic [sftp_pkg::IN_DATA_WIDTH-1:0]  s_tdata,
    input  wire logic                                m_tvalid,
    input  wire logic                                m_tready,
    // [33:0] speed, upper bits zero
    input  wire logic [sftp_pkg::OUT_DATA_WIDTH-1:0] m_tdata,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [sftp_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  wire logic [sftp_pkg::APB_DATA_WIDTH-1:0] pwdata,
    input  wire logic [sftp_pkg::APB_DATA_WIDTH-1:0] prdata,
    input  wire logic                                pready,
    output int                                       mismatch_count,
    output int                                       speeds_pending,
    output int                                       speeds_checked,
    output int                                       fresh_samples,
    output int                                       timeout_zeroes
);

    localparam logic [sftp_pkg::APB_ADDR_WIDTH-1:0] TIMEOUT_ADDR =
        sftp_pkg::APB_ADDR_WIDTH'(4 * int'(sftp_pkg::REG_TIMEOUT_TICKS));

    logic [sftp_pkg::TIME_WIDTH-1:0]        stamp_prev;
    logic signed [sftp_pkg::POS_WIDTH-1:0]  pos_prev;
    logic [sftp_pkg::IDLE_WIDTH-1:0]        idle_ticks;
    logic signed [34:0]                     speed_held;
    logic [sftp_pkg::IDLE_WIDTH-1:0]        timeout_limit;
    logic [sftp_pkg::SPEED_WIDTH-1:0]       speeds_due[$];

    initial
    begin
        mismatch_count = 0;
        speeds_pending = 0;
        speeds_checked = 0;
        fresh_samples  = 0;
        timeout_zeroes = 0;
    end

    function automatic logic [sftp_pkg::SPEED_WIDTH-1:0] next_speed(
        input logic [sftp_pkg::TIME_WIDTH-1:0]       stamp,
        input logic signed [sftp_pkg::POS_WIDTH-1:0] pos
    );
        longint num;
        longint span;
        if (stamp != stamp_prev)
        begin
            num        = 2 * (longint'(pos) - longint'(pos_prev));
            span       = longint'({32'd0, stamp - stamp_prev});
            // both operands signed, divisor positive: truncates toward zero
            speed_held = 35'(num / span);
            stamp_prev = stamp;
            pos_prev   = pos;
            idle_ticks = '0;
            fresh_samples++;
        end
        else if (idle_ticks != sftp_pkg::IDLE_MAX)
        begin
            idle_ticks++;
        end
        if (idle_ticks > timeout_limit)
        begin
            if (speed_held != 0)
                timeout_zeroes++;
            speed_held = '0;
        end
        return speed_held[sftp_pkg::SPEED_WIDTH-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_prev    = '0;
            pos_prev      = '0;
            idle_ticks    = '0;
            speed_held    = '0;
            timeout_limit = sftp_pkg::TIMEOUT_RESET;
            speeds_due.delete();
            speeds_pending = 0;
        end
        else
        begin
            if (psel && penable && pready && paddr == TIMEOUT_ADDR)
            begin
                if (pwrite)
                begin
                    timeout_limit = pwdata[sftp_pkg::IDLE_WIDTH-1:0];
                end
                else if (prdata !== sftp_pkg::APB_DATA_WIDTH'(timeout_limit))
                begin
                    $display("%0t: timeout_ticks read mismatch: expected %0d, actual %0d",
                             $time, timeout_limit, prdata);
                    mismatch_count++;
                end
            end

            if (m_tvalid && m_tready)
            begin
                if (speeds_due.size() == 0)
                begin
                    $display("%0t: unexpected speed: expected none, actual %0d",
                             $time, $signed(m_tdata[sftp_pkg::SPEED_WIDTH-1:0]));
                    mismatch_count++;
                end
                else
                begin
                    if (m_tdata !== sftp_pkg::OUT_DATA_WIDTH'(speeds_due[0]))
                    begin
                        $display("%0t: speed mismatch: expected %0d, actual %0d (tdata %h)",
                                 $time, $signed(speeds_due[0]),
                                 $signed(m_tdata[sftp_pkg::SPEED_WIDTH-1:0]), m_tdata);
                        mismatch_count++;
                    end
                    void'(speeds_due.pop_front());
                    speeds_checked++;
                end
            end

            if (s_tvalid && s_tready)
                speeds_due.push_back(next_speed(s_tdata[31:0], s_tdata[63:32]));

            speeds_pending = int'(speeds_due.size());
        end
    end

endmodule

FILE: tb/sv/tb.sv
// top of the speed_from_timestamped_position_core testbench: clock, reset, request and
// apb stimulus, result stalls and verdict; depends on sftp_pkg and speed_estimate_checker

module tb;

    localparam logic [sftp_pkg::APB_ADDR_WIDTH-1:0] TIMEOUT_ADDR =
        sftp_pkg::APB_ADDR_WIDTH'(4 * int'(sftp_pkg::REG_TIMEOUT_TICKS));

    logic                                clk      = 1'b0;
    logic                                rst_n    = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic [sftp_pkg::IN_DATA_WIDTH-1:0]  s_tdata  = '0;
    logic                                m_tready = 1'b0;
    logic                                psel     = 1'b0;
    logic                                penable  = 1'b0;
    logic                                pwrite   = 1'b0;
    logic [sftp_pkg::APB_ADDR_WIDTH-1:0] paddr    = '0;
    logic [sftp_pkg::APB_DATA_WIDTH-1:0] pwdata   = '0;

    logic                                s_tready;
    logic                                m_tvalid;
    logic [sftp_pkg::OUT_DATA_WIDTH-1:0] m_tdata;
    logic [sftp_pkg::APB_DATA_WIDTH-1:0] prdata;
    logic                                pready;

    int mismatch_count;
    int speeds_pending;
    int speeds_checked;
    int fresh_samples;
    int timeout_zeroes;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    logic [31:0] stamp_sent = '0;
    logic [31:0] pos_sent   = '0;

    speed_from_timestamped_position_core DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    speed_estimate_checker speed_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .speeds_pending (speeds_pending),
        .speeds_checked (speeds_checked),
        .fresh_samples  (fresh_samples),
        .timeout_zeroes (timeout_zeroes)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    task automatic send_sample(input logic [31:0] stamp, input logic [31:0] pos);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pos, stamp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        stamp_sent = stamp;
        pos_sent   = pos;
    endtask

    task automatic send_repeats(input int count);
        for (int i = 0; i < count; i++)
            send_sample(stamp_sent, $urandom());
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (speeds_pending != 0)
            @(negedge clk);
    endtask

    task automatic apb_access(input logic write_en, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_en;
        paddr   <= TIMEOUT_ADDR;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_timeout(input int ticks);
        drain_results();
        apb_access(1'b1, 32'(ticks));
        apb_access(1'b0, '0);
    endtask

    task automatic run_random(input int count, input int ticks);
        int pick;
        int burst_cap;
        burst_cap = (ticks < 40) ? ticks + 3 : 40;
        for (int i = 0; i < count; i++)
        begin
            // hold off until the block is empty once per phase
            if (i == count / 2)
                drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 20)
                send_repeats($urandom_range(1, burst_cap));
            else if (pick < 55)
                send_sample(stamp_sent + $urandom_range(1, 1000),
                            pos_sent + 32'($urandom_range(0, 524288)) - 32'd262144);
            else if (pick < 70)
                send_sample(stamp_sent + $urandom(), $urandom());
            else if (pick < 82)
                send_sample($urandom(), $urandom());
            else if (pick < 90)
                send_sample(stamp_sent - $urandom_range(1, 100),
                            $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000);
            else
                send_sample(stamp_sent + 1,
                            pos_sent[31] ? 32'h7fff_ffff : 32'h8000_0000);
        end
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // reset value of the timeout register, then the directed samples
        send_idle_pct = 8;
        recv_idle_pct = 62;
        apb_access(1'b0, '0);
        send_sample(32'd0, 32'h0003_0000);
        send_sample(32'd5, 32'h0001_0000);
        send_sample(32'd6, 32'h7fff_ffff);
        send_sample(32'd7, 32'h8000_0000);
        send_sample(32'd8, 32'h7fff_ffff);
        send_sample(32'd8, 32'h0000_0000);
        send_sample(32'hffff_ffff, 32'h0000_0000);
        send_sample(32'd3, 32'hffff_ffff);
        send_sample(32'd6, 32'hffff_fffe);
        send_sample(32'd9, 32'hffff_fff9);
        send_sample(32'h8000_0009, 32'h1234_5678);

        set_timeout(0);
        send_repeats(1);
        send_sample(stamp_sent + 2, 32'h0010_0000);
        set_timeout(1);
        send_repeats(2);
        send_sample(stamp_sent + 1, 32'hfff0_0000);

        // idle count saturates at its maximum and must not wrap
        set_timeout(511);
        send_sample(stamp_sent + 1, pos_sent + 32'h0100_0000);
        send_repeats(512);
        set_timeout(510);
        send_repeats(1);

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 8 : (mode == 1) ? 62 : 0;
            recv_idle_pct = (mode == 0) ? 62 : (mode == 1) ? 8 : 0;
            for (int sub = 0; sub < 2; sub++)
            begin
                if (sub == 0)
                begin
                    set_timeout($urandom_range(0, 12));
                    run_random(5, 12);
                end
                else
                begin
                    set_timeout($urandom_range(0, 510));
                    run_random(5, 510);
                end
            end
        end

        drain_results();
        repeat (40) @(negedge clk);
        $display("checked %0d speeds from %0d new samples, %0d zeroed by the idle timeout",
                 speeds_checked, fresh_samples, timeout_zeroes);
        $display("timeouts 0, 1, 300, 510, 511 and random, with stalls on both channels");
        if (mismatch_count == 0)
            $display("speed_from_timestamped_position_core regression: pass");
        else
            $display("speed_from_timestamped_position_core regression: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d speeds outstanding", speeds_pending);
        $display("speed_from_timestamped_position_core regression: fail");
        $finish;
    end

endmodule
